// ----- hdl/adpd_pkg.sv -----
// adpd_pkg: shared types and constants of the detent position debouncer
// used by the interfaces, the register file, the controller and the datapath
// no dependencies

package adpd_pkg;

    // fixed field widths
    localparam int LEVEL_W    = 12;
    localparam int CLASS_W    = 3;
    localparam int STABLE_W   = 16;
    localparam int PERIOD_W   = 8;
    localparam int NUM_POS    = 5;
    localparam int CFG_DATA_W = 16;
    localparam int CFG_IDX_W  = 3;

    // register indexes of the configuration port
    localparam logic [CFG_IDX_W-1:0] REG_NOM_POS1      = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_NOM_POS2      = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_NOM_POS3      = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_NOM_POS4      = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_NOM_POS5      = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_MATCH_WINDOW  = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_DEBOUNCE_MS   = 3'd6;
    localparam logic [CFG_IDX_W-1:0] REG_SAMPLE_PERIOD = 3'd7;

    // class code for a level between positions
    localparam logic [CLASS_W-1:0] CLASS_BETWEEN = 3'd0;

    typedef struct packed {
        logic [NUM_POS-1:0][LEVEL_W-1:0] nominal;
        logic [LEVEL_W-1:0]              window;
        logic [STABLE_W-1:0]             debounce;
        logic [PERIOD_W-1:0]             period;
    } cfg_t;

    // controller to datapath
    typedef struct packed {
        logic accept;
        logic scan_step;
        logic div_load;
        logic div_step;
        logic cls_step;
        logic finish;
    } cmd_t;

    // datapath to controller
    typedef struct packed {
        logic take_sample;
        logic scan_last;
        logic cls_done;
    } sts_t;

    typedef struct packed {
        logic               sampled;
        logic [LEVEL_W-1:0] raw_level;
        logic [LEVEL_W-1:0] mean_level;
        logic [CLASS_W-1:0] instant_pos;
        logic [CLASS_W-1:0] confirmed_pos;
        logic               change_event;
    } result_t;

endpackage

// ----- hdl/adpd_if.sv -----
// adpd_if: valid/ready channels of the detent position debouncer
// tick channel carries the converter reading, status channel the result
// depends on adpd_pkg

interface adpd_tick_if;
    import adpd_pkg::*;

    logic               valid;
    logic               ready;
    logic [LEVEL_W-1:0] adc_sample;

    modport source (output valid, output adc_sample, input ready);
    modport sink (input valid, input adc_sample, output ready);
endinterface

interface adpd_status_if;
    import adpd_pkg::*;

    logic               valid;
    logic               ready;
    logic               sampled;
    logic [LEVEL_W-1:0] raw_level;
    logic [LEVEL_W-1:0] mean_level;
    logic [CLASS_W-1:0] instant_pos;
    logic [CLASS_W-1:0] confirmed_pos;
    logic               change_event;

    modport source (
        output valid, output sampled, output raw_level, output mean_level,
        output instant_pos, output confirmed_pos, output change_event,
        input ready
    );
    modport sink (
        input valid, input sampled, input raw_level, input mean_level,
        input instant_pos, input confirmed_pos, input change_event,
        output ready
    );
endinterface

// ----- hdl/adpd_regs.sv -----
// adpd_regs: configuration registers of the detent position debouncer
// written through a plain write port, no read-back
// depends on adpd_pkg

module adpd_regs (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               cfg_wr_en,
    input  logic [adpd_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [adpd_pkg::CFG_DATA_W-1:0]    cfg_data,
    output adpd_pkg::cfg_t                     cfg
);
    import adpd_pkg::*;

    localparam cfg_t CFG_RESET = '{
        nominal:  {12'd3686, 12'd2867, 12'd2048, 12'd1229, 12'd410},
        window:   12'd150,
        debounce: 16'd100,
        period:   8'd10
    };

    cfg_t cfg_reg;
    cfg_t cfg_next;

    // register write decode
    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_wr_en)
        begin
            unique case (cfg_index)
                REG_NOM_POS1:      cfg_next.nominal[0] = cfg_data[LEVEL_W-1:0];
                REG_NOM_POS2:      cfg_next.nominal[1] = cfg_data[LEVEL_W-1:0];
                REG_NOM_POS3:      cfg_next.nominal[2] = cfg_data[LEVEL_W-1:0];
                REG_NOM_POS4:      cfg_next.nominal[3] = cfg_data[LEVEL_W-1:0];
                REG_NOM_POS5:      cfg_next.nominal[4] = cfg_data[LEVEL_W-1:0];
                REG_MATCH_WINDOW:  cfg_next.window     = cfg_data[LEVEL_W-1:0];
                REG_DEBOUNCE_MS:   cfg_next.debounce   = cfg_data[STABLE_W-1:0];
                REG_SAMPLE_PERIOD: cfg_next.period     = cfg_data[PERIOD_W-1:0];
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            cfg_reg <= CFG_RESET;
        else
            cfg_reg <= cfg_next;
    end

    assign cfg = cfg_reg;

endmodule

// ----- hdl/adpd_ctrl.sv -----
// adpd_ctrl: sequencing state machine of the detent position debouncer
// steps the datapath through scan, trim, divide, classify and finish
// depends on adpd_pkg

module adpd_ctrl (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             in_valid,
    output logic             in_ready,
    output logic             out_valid,
    input  logic             out_ready,
    input  adpd_pkg::sts_t   sts,
    output adpd_pkg::cmd_t   cmd
);
    import adpd_pkg::*;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SCAN,
        ST_TRIM,
        ST_DIVIDE,
        ST_CLASSIFY,
        ST_FINISH
    } state_t;

    state_t state_reg;
    state_t state_next;
    logic   out_valid_reg;
    logic   out_valid_next;
    logic   out_free;

    // result register can take a new value this cycle
    assign out_free = !out_valid_reg || out_ready;
    assign in_ready = (state_reg == ST_IDLE) && out_free;

    // next state and commands
    always_comb
    begin
        state_next     = state_reg;
        out_valid_next = out_valid_reg && !out_ready;
        cmd            = '0;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_valid && in_ready)
                begin
                    cmd.accept = 1'b1;
                    if (sts.take_sample)
                        state_next = ST_SCAN;
                    else
                        out_valid_next = 1'b1;
                end
            end
            ST_SCAN:
            begin
                cmd.scan_step = 1'b1;
                if (sts.scan_last)
                    state_next = ST_TRIM;
            end
            ST_TRIM:
            begin
                cmd.div_load = 1'b1;
                state_next   = ST_DIVIDE;
            end
            ST_DIVIDE:
            begin
                cmd.div_step = 1'b1;
                state_next   = ST_CLASSIFY;
            end
            ST_CLASSIFY:
            begin
                cmd.cls_step = 1'b1;
                if (sts.cls_done)
                    state_next = ST_FINISH;
            end
            ST_FINISH:
            begin
                if (out_free)
                begin
                    cmd.finish     = 1'b1;
                    out_valid_next = 1'b1;
                    state_next     = ST_IDLE;
                end
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign out_valid = out_valid_reg;

endmodule

// ----- hdl/adpd_dp.sv -----
// adpd_dp: datapath of the detent position debouncer
// sample ring, sum/min/max scan, reciprocal divider, classifier, debounce
// depends on adpd_pkg

module adpd_dp #(
    parameter int FILTER_LEN     = 10,
    parameter int SAMPLE_STEP_MS = 10,
    parameter int ADC_WIDTH      = 12
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  adpd_pkg::cfg_t                  cfg,
    input  adpd_pkg::cmd_t                  cmd,
    output adpd_pkg::sts_t                  sts,
    input  logic [adpd_pkg::LEVEL_W-1:0]    adc_sample,
    output adpd_pkg::result_t               result
);
    import adpd_pkg::*;

    localparam int SMP_W   = (ADC_WIDTH < LEVEL_W) ? ADC_WIDTH : LEVEL_W;
    localparam int RING_IW = $clog2(FILTER_LEN);
    localparam int SUM_W   = $clog2(FILTER_LEN) + SMP_W;
    localparam int DIVISOR = FILTER_LEN - 2;
    localparam int RECIP_SH = SUM_W + $clog2(DIVISOR);
    localparam int RECIP_W  = SUM_W + 1;
    localparam int PROD_W   = SUM_W + RECIP_W;
    localparam longint RECIP = ((longint'(1) << RECIP_SH) + longint'(DIVISOR) - 1)
                               / longint'(DIVISOR);
    localparam int STEP_LIMIT = 65535 - SAMPLE_STEP_MS;

    // prescaler
    logic [PERIOD_W-1:0] tick_cnt_reg;
    logic [PERIOD_W-1:0] tick_cnt_next;
    logic                take_sample;

    assign tick_cnt_next = tick_cnt_reg + 1'b1;
    assign take_sample   = tick_cnt_next >= cfg.period;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            tick_cnt_reg <= '0;
        else if (cmd.accept)
            tick_cnt_reg <= take_sample ? '0 : tick_cnt_next;
    end

    // sample ring and last raw sample
    logic [SMP_W-1:0]   ring_reg [FILTER_LEN];
    logic [RING_IW-1:0] wr_idx_reg;
    logic [SMP_W-1:0]   last_raw_reg;
    logic               write_sample;

    assign write_sample = cmd.accept && take_sample;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int k = 0; k < FILTER_LEN; k++)
                ring_reg[k] <= '0;
            wr_idx_reg   <= '0;
            last_raw_reg <= '0;
        end
        else if (write_sample)
        begin
            ring_reg[wr_idx_reg] <= adc_sample[SMP_W-1:0];
            last_raw_reg         <= adc_sample[SMP_W-1:0];
            if (wr_idx_reg == RING_IW'(FILTER_LEN - 1))
                wr_idx_reg <= '0;
            else
                wr_idx_reg <= wr_idx_reg + 1'b1;
        end
    end

    // sum, minimum and maximum, one entry per cycle
    logic [RING_IW-1:0] scan_idx_reg;
    logic [SUM_W-1:0]   sum_reg;
    logic [SMP_W-1:0]   lo_reg;
    logic [SMP_W-1:0]   hi_reg;
    logic [SMP_W-1:0]   ring_rd;

    assign ring_rd = ring_reg[scan_idx_reg];

    always_ff @(posedge clk)
    begin
        if (write_sample)
        begin
            scan_idx_reg <= '0;
            sum_reg      <= '0;
            lo_reg       <= '1;
            hi_reg       <= '0;
        end
        else if (cmd.scan_step)
        begin
            scan_idx_reg <= scan_idx_reg + 1'b1;
            sum_reg      <= sum_reg + SUM_W'(ring_rd);
            if (ring_rd < lo_reg)
                lo_reg <= ring_rd;
            if (ring_rd > hi_reg)
                hi_reg <= ring_rd;
        end
    end

    // divide the trimmed sum by the constant depth minus two with a reciprocal
    // multiply; a shift of the sum width plus log2 of the divisor keeps it exact
    logic [SUM_W-1:0]  trimmed;
    logic [SUM_W-1:0]  trim_reg;
    logic [SUM_W-1:0]  quo_reg;
    logic [PROD_W-1:0] quo_prod;

    assign trimmed  = sum_reg - SUM_W'(lo_reg) - SUM_W'(hi_reg);
    assign quo_prod = PROD_W'(trim_reg) * PROD_W'(RECIP);

    always_ff @(posedge clk)
    begin
        if (cmd.div_load)
            trim_reg <= trimmed;
        else if (cmd.div_step)
            quo_reg <= SUM_W'(quo_prod >> RECIP_SH);
    end

    // classifier, one nominal per cycle in priority order
    logic [LEVEL_W-1:0] level;
    logic [LEVEL_W-1:0] nom;
    logic [LEVEL_W-1:0] level_gap;
    logic               match;
    logic [CLASS_W-1:0] pos_idx_reg;
    logic [CLASS_W-1:0] found_reg;

    assign level     = LEVEL_W'(quo_reg[SMP_W-1:0]);
    assign nom       = cfg.nominal[pos_idx_reg];
    assign level_gap = (level > nom) ? level - nom : nom - level;
    assign match     = level_gap <= cfg.window;

    always_ff @(posedge clk)
    begin
        if (cmd.div_load)
            pos_idx_reg <= '0;
        else if (cmd.cls_step)
        begin
            pos_idx_reg <= pos_idx_reg + 1'b1;
            found_reg   <= match ? pos_idx_reg + 1'b1 : CLASS_BETWEEN;
        end
    end

    // stability counter and confirmation
    logic [LEVEL_W-1:0]  last_mean_reg;
    logic [CLASS_W-1:0]  cur_class_reg;
    logic [CLASS_W-1:0]  cur_class_next;
    logic [CLASS_W-1:0]  deb_class_reg;
    logic [STABLE_W-1:0] stable_reg;
    logic [STABLE_W-1:0] stable_next;
    logic                changed;

    always_comb
    begin
        cur_class_next = cur_class_reg;
        stable_next    = stable_reg;
        if (found_reg != cur_class_reg)
        begin
            cur_class_next = found_reg;
            stable_next    = STABLE_W'(SAMPLE_STEP_MS);
        end
        else if (stable_reg <= STABLE_W'(STEP_LIMIT))
            stable_next = stable_reg + STABLE_W'(SAMPLE_STEP_MS);
        changed = (stable_next >= cfg.debounce) && (deb_class_reg != cur_class_next);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            last_mean_reg <= '0;
            cur_class_reg <= CLASS_BETWEEN;
            deb_class_reg <= CLASS_BETWEEN;
            stable_reg    <= '0;
        end
        else if (cmd.finish)
        begin
            last_mean_reg <= level;
            cur_class_reg <= cur_class_next;
            stable_reg    <= stable_next;
            if (changed)
                deb_class_reg <= cur_class_next;
        end
    end

    // result register
    result_t result_reg;

    always_ff @(posedge clk)
    begin
        if (cmd.finish)
        begin
            result_reg.sampled       <= 1'b1;
            result_reg.raw_level     <= LEVEL_W'(last_raw_reg);
            result_reg.mean_level    <= level;
            result_reg.instant_pos   <= cur_class_next;
            result_reg.confirmed_pos <= changed ? cur_class_next : deb_class_reg;
            result_reg.change_event  <= changed;
        end
        else if (cmd.accept && !take_sample)
        begin
            result_reg.sampled       <= 1'b0;
            result_reg.raw_level     <= LEVEL_W'(last_raw_reg);
            result_reg.mean_level    <= last_mean_reg;
            result_reg.instant_pos   <= cur_class_reg;
            result_reg.confirmed_pos <= deb_class_reg;
            result_reg.change_event  <= 1'b0;
        end
    end

    assign result = result_reg;

    // status to the controller
    assign sts.take_sample = take_sample;
    assign sts.scan_last   = scan_idx_reg == RING_IW'(FILTER_LEN - 1);
    assign sts.cls_done    = match || (pos_idx_reg == CLASS_W'(NUM_POS - 1));

endmodule

// ----- hdl/adc_position_detent_debouncer.sv -----
// adc_position_detent_debouncer: top level of the detent position debouncer
// ties together the register file, the controller and the datapath
// depends on adpd_pkg, adpd_if, adpd_regs, adpd_ctrl, adpd_dp

// Every transfer on tick is one clock tick of the prescaler carrying the
// current converter reading, and each produces exactly one transfer on
// status. A sampling tick writes the ring, then scans it one entry per
// cycle for sum, minimum and maximum, latches the trimmed sum, divides it
// by FILTER_LEN-2 with one reciprocal multiplication, and checks the five
// nominals one per cycle until one matches. A finished result waits in
// an output register; the next tick is taken once that register is free.
// Configuration may be written only while no tick is in progress.

module adc_position_detent_debouncer #(
    parameter int FILTER_LEN     = 10,
    parameter int SAMPLE_STEP_MS = 10,
    parameter int ADC_WIDTH      = 12
) (
    input  logic                             clk,
    input  logic                             rst_n,
    adpd_tick_if.sink                        tick,
    adpd_status_if.source                    status,
    input  logic                             cfg_wr_en,
    input  logic [adpd_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [adpd_pkg::CFG_DATA_W-1:0]  cfg_data
);
    import adpd_pkg::*;

    cfg_t    cfg;
    cmd_t    cmd;
    sts_t    sts;
    result_t result;

    // configuration registers
    adpd_regs u_regs (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    // sequencing
    adpd_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (tick.valid),
        .in_ready  (tick.ready),
        .out_valid (status.valid),
        .out_ready (status.ready),
        .sts       (sts),
        .cmd       (cmd)
    );

    // filter, classifier and debounce
    adpd_dp #(
        .FILTER_LEN     (FILTER_LEN),
        .SAMPLE_STEP_MS (SAMPLE_STEP_MS),
        .ADC_WIDTH      (ADC_WIDTH)
    ) u_dp (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg        (cfg),
        .cmd        (cmd),
        .sts        (sts),
        .adc_sample (tick.adc_sample),
        .result     (result)
    );

    // result payload onto the status channel
    assign status.sampled       = result.sampled;
    assign status.raw_level     = result.raw_level;
    assign status.mean_level    = result.mean_level;
    assign status.instant_pos   = result.instant_pos;
    assign status.confirmed_pos = result.confirmed_pos;
    assign status.change_event  = result.change_event;

endmodule

// ----- test/tb_adc_position_detent_debouncer.sv -----
// tb_adc_position_detent_debouncer: self-checking bench for the detent position debouncer
// directed stimulus table and random phases, checked by a predictor or by fixed expectations
// depends on adpd_pkg, adpd_if and the adc_position_detent_debouncer rtl

`timescale 1ns / 1ps

module tb_adc_position_detent_debouncer;
    import adpd_pkg::*;

    localparam int RING_DEPTH      = 10;
    localparam int MS_PER_SAMPLE   = 10;
    localparam int LEVEL_MAX       = (1 << LEVEL_W) - 1;
    localparam int STABLE_MAX      = (1 << STABLE_W) - 1;
    localparam int RESET_CYCLES    = 4;
    localparam int DRAIN_CYCLES    = 40;
    localparam int RANDOM_PHASES   = 12;
    localparam int PHASE_TICKS     = 118;
    localparam int HOLD_AT_RESULT  = 500;
    localparam int LONG_HOLD       = 600;
    localparam int MAX_PRINTED     = 50;
    localparam int unsigned CYCLE_LIMIT = 3_000_000;

    typedef enum logic {ROW_TICK, ROW_REG} row_kind_t;

    typedef struct {
        row_kind_t              kind;
        logic [CFG_IDX_W-1:0]   idx;
        logic [CFG_DATA_W-1:0]  value;
        int                     reps;
        bit                     known;
        result_t                want;
    } plan_row_t;

    logic clk;
    logic rst_n;
    logic                  cfg_wr_en;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;

    adpd_tick_if   tick_ch ();
    adpd_status_if status_ch ();

    adc_position_detent_debouncer #(
        .FILTER_LEN     (RING_DEPTH),
        .SAMPLE_STEP_MS (MS_PER_SAMPLE),
        .ADC_WIDTH      (LEVEL_W)
    ) dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .tick      (tick_ch),
        .status    (status_ch),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    // predictor copy of the registers
    logic [LEVEL_W-1:0]  nom_cfg [NUM_POS] = '{12'd410, 12'd1229, 12'd2048, 12'd2867, 12'd3686};
    logic [LEVEL_W-1:0]  window_cfg   = 12'd150;
    logic [STABLE_W-1:0] debounce_cfg = 16'd100;
    logic [PERIOD_W-1:0] period_cfg   = 8'd10;

    // predictor copy of the filter and debounce state
    logic [LEVEL_W-1:0] ring_mem [RING_DEPTH] = '{default: '0};
    int unsigned        ring_wr    = 0;
    logic [PERIOD_W-1:0] tick_cnt  = '0;
    int unsigned        stable_count = 0;
    logic [LEVEL_W-1:0] raw_hold   = '0;
    logic [LEVEL_W-1:0] mean_hold  = '0;
    logic [CLASS_W-1:0] class_now  = CLASS_BETWEEN;
    logic [CLASS_W-1:0] class_conf = CLASS_BETWEEN;

    result_t     due_status_q [$];
    plan_row_t   plan_q [$];
    int          mismatch_count = 0;
    int          results_seen = 0;
    int unsigned cycle_count = 0;
    bit          source_burst = 1'b0;
    bit          sink_burst = 1'b0;

    // clock
    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
    end

    // run limit
    initial
    begin
        wait (cycle_count >= CYCLE_LIMIT);
        $display("Verification failed");
        $finish;
    end

    function automatic logic [CLASS_W-1:0] classify_mean(input logic [LEVEL_W-1:0] level);
        int level_gap;
        for (int p = 0; p < NUM_POS; p++)
        begin
            level_gap = (level > nom_cfg[p]) ? int'(level) - int'(nom_cfg[p])
                                             : int'(nom_cfg[p]) - int'(level);
            if (level_gap <= int'(window_cfg))
                return CLASS_W'(p + 1);
        end
        return CLASS_BETWEEN;
    endfunction

    // one tick through the prescaler, trimmed mean, classifier and debounce
    function automatic result_t advance_debouncer(input logic [LEVEL_W-1:0] level);
        result_t             res;
        logic [PERIOD_W-1:0] next_count;
        int unsigned         total;
        int unsigned         lo;
        int unsigned         hi;
        logic [CLASS_W-1:0]  cls;
        res = '0;
        next_count = tick_cnt + 1'b1;
        if (next_count < period_cfg)
        begin
            tick_cnt = next_count;
        end
        else
        begin
            tick_cnt = '0;
            res.sampled = 1'b1;
            raw_hold = level;
            ring_mem[ring_wr] = level;
            ring_wr = (ring_wr + 1) % RING_DEPTH;
            total = 0;
            lo = LEVEL_MAX;
            hi = 0;
            foreach (ring_mem[k])
            begin
                total += ring_mem[k];
                if (ring_mem[k] < lo)
                    lo = ring_mem[k];
                if (ring_mem[k] > hi)
                    hi = ring_mem[k];
            end
            mean_hold = LEVEL_W'((total - lo - hi) / (RING_DEPTH - 2));
            cls = classify_mean(mean_hold);
            // stability time restarts on a new class and saturates near the top
            if (cls != class_now)
            begin
                class_now = cls;
                stable_count = MS_PER_SAMPLE;
            end
            else if (stable_count <= STABLE_MAX - MS_PER_SAMPLE)
            begin
                stable_count += MS_PER_SAMPLE;
            end
            if (stable_count >= debounce_cfg && class_conf != class_now)
            begin
                class_conf = class_now;
                res.change_event = 1'b1;
            end
        end
        res.raw_level     = raw_hold;
        res.mean_level    = mean_hold;
        res.instant_pos   = class_now;
        res.confirmed_pos = class_conf;
        return res;
    endfunction

    function automatic void store_reg(input logic [CFG_IDX_W-1:0] idx,
                                      input logic [CFG_DATA_W-1:0] value);
        case (idx)
            REG_NOM_POS1:      nom_cfg[0] = value[LEVEL_W-1:0];
            REG_NOM_POS2:      nom_cfg[1] = value[LEVEL_W-1:0];
            REG_NOM_POS3:      nom_cfg[2] = value[LEVEL_W-1:0];
            REG_NOM_POS4:      nom_cfg[3] = value[LEVEL_W-1:0];
            REG_NOM_POS5:      nom_cfg[4] = value[LEVEL_W-1:0];
            REG_MATCH_WINDOW:  window_cfg = value[LEVEL_W-1:0];
            REG_DEBOUNCE_MS:   debounce_cfg = value[STABLE_W-1:0];
            REG_SAMPLE_PERIOD: period_cfg = value[PERIOD_W-1:0];
            default: ;
        endcase
    endfunction

    function automatic int idle_cycles(input bit burst);
        int r;
        r = $urandom_range(0, 99);
        if (burst || r < 55)
            return 0;
        if (r < 92)
            return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    function automatic logic [LEVEL_W-1:0] clamp_level(input int v);
        if (v < 0)
            return '0;
        if (v > LEVEL_MAX)
            return LEVEL_W'(LEVEL_MAX);
        return LEVEL_W'(v);
    endfunction

    function automatic result_t status_of(input logic took, input int raw, input int mean,
                                          input logic [CLASS_W-1:0] inst,
                                          input logic [CLASS_W-1:0] conf, input logic chg);
        result_t res;
        res.sampled       = took;
        res.raw_level     = LEVEL_W'(raw);
        res.mean_level    = LEVEL_W'(mean);
        res.instant_pos   = inst;
        res.confirmed_pos = conf;
        res.change_event  = chg;
        return res;
    endfunction

    function automatic plan_row_t tick_row(input int level, input int reps);
        plan_row_t row;
        row.kind  = ROW_TICK;
        row.idx   = REG_NOM_POS1;
        row.value = CFG_DATA_W'(level);
        row.reps  = reps;
        row.known = 1'b0;
        row.want  = '0;
        return row;
    endfunction

    function automatic plan_row_t known_row(input int level, input int reps, input result_t want);
        plan_row_t row;
        row = tick_row(level, reps);
        row.known = 1'b1;
        row.want  = want;
        return row;
    endfunction

    function automatic plan_row_t reg_row(input logic [CFG_IDX_W-1:0] idx, input int value);
        plan_row_t row;
        row = tick_row(0, 0);
        row.kind  = ROW_REG;
        row.idx   = idx;
        row.value = CFG_DATA_W'(value);
        return row;
    endfunction

    task automatic flag_error(input string msg);
        mismatch_count++;
        // keep the log short when something goes badly wrong
        if (mismatch_count <= MAX_PRINTED)
            $display("ERROR at %0t ns: %s", $realtime, msg);
    endtask

    // compare one status transfer against the oldest pending expectation
    task automatic check_status();
        result_t want;
        if (due_status_q.size() == 0)
        begin
            flag_error("status transfer with no tick pending");
            return;
        end
        want = due_status_q.pop_front();
        if (status_ch.sampled !== want.sampled)
            flag_error($sformatf("sampled got %0d want %0d", status_ch.sampled, want.sampled));
        if (status_ch.raw_level !== want.raw_level)
            flag_error($sformatf("raw_level got %0d want %0d",
                                 status_ch.raw_level, want.raw_level));
        if (status_ch.mean_level !== want.mean_level)
            flag_error($sformatf("mean_level got %0d want %0d",
                                 status_ch.mean_level, want.mean_level));
        if (status_ch.instant_pos !== want.instant_pos)
            flag_error($sformatf("instant_pos got %0d want %0d",
                                 status_ch.instant_pos, want.instant_pos));
        if (status_ch.confirmed_pos !== want.confirmed_pos)
            flag_error($sformatf("confirmed_pos got %0d want %0d",
                                 status_ch.confirmed_pos, want.confirmed_pos));
        if (status_ch.change_event !== want.change_event)
            flag_error($sformatf("change_event got %0d want %0d",
                                 status_ch.change_event, want.change_event));
    endtask

    // status sink: random stalls, one long hold, check at the falling edge
    initial
    begin
        int stall_left;
        stall_left = 0;
        status_ch.ready <= 1'b0;
        wait (rst_n === 1'b1);
        forever
        begin
            @(posedge clk);
            status_ch.ready <= (stall_left == 0);
            if (stall_left > 0)
                stall_left--;
            @(negedge clk);
            if (status_ch.valid === 1'b1 && status_ch.ready === 1'b1)
            begin
                check_status();
                results_seen++;
                if (results_seen == HOLD_AT_RESULT)
                    stall_left = LONG_HOLD;
                else
                    stall_left = idle_cycles(sink_burst);
                if (results_seen % 128 == 0)
                    sink_burst = ($urandom_range(0, 3) == 0);
            end
        end
    end

    // one tick transfer; predicts at the cycle the transfer is seen
    task automatic send_tick(input logic [LEVEL_W-1:0] level, input bit known,
                             input result_t want);
        int      gap;
        result_t predicted;
        gap = idle_cycles(source_burst);
        if (gap > 0)
        begin
            tick_ch.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        tick_ch.valid <= 1'b1;
        tick_ch.adc_sample <= level;
        do
            @(negedge clk);
        while (tick_ch.ready !== 1'b1);
        predicted = advance_debouncer(level);
        due_status_q.push_back(known ? want : predicted);
        @(posedge clk);
    endtask

    // stop offering ticks and let every pending status come back
    task automatic drain_and_idle();
        tick_ch.valid <= 1'b0;
        while (due_status_q.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input int value);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= CFG_DATA_W'(value);
        @(posedge clk);
        cfg_wr_en <= 1'b0;
        @(posedge clk);
        store_reg(idx, CFG_DATA_W'(value));
    endtask

    // new register set for a random phase, extremes mixed in
    task automatic program_random_setup(input int phase);
        int setup [8];
        int r;
        drain_and_idle();
        for (int p = 0; p < NUM_POS; p++)
        begin
            r = $urandom_range(0, 9);
            if (r < 7)
                setup[REG_NOM_POS1 + p] = p * 820 + $urandom_range(0, 400);
            else
                setup[REG_NOM_POS1 + p] = $urandom_range(0, LEVEL_MAX);
        end
        if (phase % 4 == 0)
        begin
            setup[REG_NOM_POS1] = 0;
            setup[REG_NOM_POS5] = LEVEL_MAX;
        end
        r = $urandom_range(0, 9);
        setup[REG_MATCH_WINDOW] = (r == 0) ? 0 : (r == 1) ? LEVEL_MAX : $urandom_range(30, 400);
        r = $urandom_range(0, 9);
        setup[REG_DEBOUNCE_MS] = (r == 0) ? 0 : (r == 1) ? STABLE_MAX : $urandom_range(10, 250);
        r = $urandom_range(0, 9);
        if (phase == 3)
            setup[REG_SAMPLE_PERIOD] = (1 << PERIOD_W) - 1;
        else if (r < 2)
            setup[REG_SAMPLE_PERIOD] = $urandom_range(4, 20);
        else
            setup[REG_SAMPLE_PERIOD] = $urandom_range(1, 3);
        for (int i = 0; i < 8; i++)
            write_reg(CFG_IDX_W'(i), setup[i]);
    endtask

    // mostly held levels near a nominal with light noise, some stray readings
    task automatic drive_random_phase(input int count);
        int left;
        int run;
        int per;
        int center;
        int span;
        int p;
        int r;
        left = count;
        source_burst = ($urandom_range(0, 3) == 0);
        per = (period_cfg == 0) ? 1 : int'(period_cfg);
        while (left > 0)
        begin
            r = $urandom_range(0, 99);
            if (r < 15)
            begin
                send_tick(LEVEL_W'($urandom_range(0, LEVEL_MAX)), 1'b0, '0);
                left--;
            end
            else
            begin
                if (r < 22)
                begin
                    center = (r < 18) ? 0 : LEVEL_MAX;
                end
                else
                begin
                    p = $urandom_range(0, NUM_POS - 1);
                    span = int'(window_cfg) + 40;
                    center = int'(nom_cfg[p]) + int'($urandom_range(0, 2 * span)) - span;
                end
                run = int'($urandom_range(3, 25)) * per;
                if (run > left)
                    run = left;
                repeat (run)
                begin
                    send_tick(clamp_level(center + int'($urandom_range(0, 8)) - 4), 1'b0, '0);
                    left--;
                end
            end
        end
    endtask

    // stimulus
    initial
    begin
        rst_n <= 1'b0;
        cfg_wr_en <= 1'b0;
        cfg_index <= REG_NOM_POS1;
        cfg_data <= '0;
        tick_ch.valid <= 1'b0;
        tick_ch.adc_sample <= '0;

        // ticks after reset that take no sample
        plan_q.push_back(known_row(12'hABC, 3, status_of(1'b0, 0, 0, CLASS_BETWEEN,
                                                         CLASS_BETWEEN, 1'b0)));
        // period lowered below the running count samples at once
        plan_q.push_back(reg_row(REG_SAMPLE_PERIOD, 2));
        plan_q.push_back(known_row(LEVEL_MAX, 1, status_of(1'b1, LEVEL_MAX, 0, CLASS_BETWEEN,
                                                           CLASS_BETWEEN, 1'b0)));
        plan_q.push_back(known_row(12'h555, 1, status_of(1'b0, LEVEL_MAX, 0, CLASS_BETWEEN,
                                                         CLASS_BETWEEN, 1'b0)));
        // period zero samples every tick
        plan_q.push_back(reg_row(REG_SAMPLE_PERIOD, 0));
        plan_q.push_back(tick_row(0, 2));
        // zero debounce confirms the first classification at once
        plan_q.push_back(reg_row(REG_NOM_POS1, 0));
        plan_q.push_back(reg_row(REG_MATCH_WINDOW, 0));
        plan_q.push_back(reg_row(REG_DEBOUNCE_MS, 0));
        plan_q.push_back(tick_row(0, 1));
        // full scale readings fill the ring, longest debounce never confirms
        plan_q.push_back(reg_row(REG_MATCH_WINDOW, 100));
        plan_q.push_back(reg_row(REG_DEBOUNCE_MS, STABLE_MAX));
        plan_q.push_back(reg_row(REG_NOM_POS5, LEVEL_MAX));
        plan_q.push_back(tick_row(LEVEL_MAX, 10));
        // mid scale move with a short debounce
        plan_q.push_back(reg_row(REG_DEBOUNCE_MS, 20));
        plan_q.push_back(reg_row(REG_NOM_POS2, 1000));
        plan_q.push_back(reg_row(REG_NOM_POS3, 2000));
        plan_q.push_back(reg_row(REG_NOM_POS4, 3000));
        plan_q.push_back(reg_row(REG_SAMPLE_PERIOD, 3));
        plan_q.push_back(tick_row(2000, 9));

        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (plan_q[i])
        begin
            if (plan_q[i].kind == ROW_REG)
            begin
                drain_and_idle();
                write_reg(plan_q[i].idx, plan_q[i].value);
            end
            else
            begin
                repeat (plan_q[i].reps)
                    send_tick(plan_q[i].value[LEVEL_W-1:0], plan_q[i].known, plan_q[i].want);
            end
        end

        for (int phase = 0; phase < RANDOM_PHASES; phase++)
        begin
            program_random_setup(phase);
            drive_random_phase(PHASE_TICKS);
        end

        drain_and_idle();
        if (mismatch_count == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule
